// ===== hw/rtl/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared widths, constants, state encoding and control/status bundles for the
// trial-division prime counter.
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int VALUE_W   = 32;
    localparam int MAG_W     = 31;
    localparam int DIV_W     = 16;
    localparam int SQ_W      = 32;
    localparam int TALLY_W   = 32;
    localparam int REM_CNT_W = 5;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [DIV_W-1:0]   FIRST_DIV = 16'd3;
    localparam logic [SQ_W-1:0]    FIRST_SQ  = 32'd9;
    localparam logic [SQ_W-1:0]    SQ_STEP_C = 32'd4;
    localparam logic [MAG_W-1:0]   MAG_TWO   = 31'd2;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_CLASSIFY = 5'b00010,
        ST_CHECK    = 5'b00100,
        ST_DIVIDE   = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic init_trial;
        logic start_div;
        logic advance;
        logic set_verdict;
        logic verdict;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_two;
        logic settled_no;
        logic sq_over;
        logic div_done;
        logic rem_zero;
        logic last;
        logic out_blocked;
    } sts_t;

endpackage

// ===== hw/rtl/pcd_rem.sv =====
// ----------------------------------------------------------------------------
// pcd_rem
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pcd_rem (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pcd_pkg::MAG_W-1:0]  dividend,
    input  logic [pcd_pkg::DIV_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic                       rem_zero
);
    import pcd_pkg::*;

    logic [MAG_W-1:0]     bits_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [REM_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    assign trial = {rem_reg, bits_reg[MAG_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == REM_CNT_W'(MAG_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // shift in the next dividend bit, subtract when it fits
    always_ff @(posedge aclk) begin
        if (start) begin
            bits_reg <= dividend;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            bits_reg <= {bits_reg[MAG_W-2:0], 1'b0};
            rem_reg  <= (trial >= {1'b0, divisor}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("remainder restarted while busy");

    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("remainder done held for more than one cycle");

endmodule

// ===== hw/rtl/pcd_datapath.sv =====
// ----------------------------------------------------------------------------
// pcd_datapath
// Operand, divisor and square registers, remainder unit, tally and output register.
// ----------------------------------------------------------------------------
module pcd_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pcd_pkg::cmd_t                 cmd,
    output pcd_pkg::sts_t                 sts,
    input  logic [pcd_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  logic                          s_tlast,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [pcd_pkg::TALLY_W-1:0]   m_tdata    // [31:0] prime_total
);
    import pcd_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic               verdict_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic [TALLY_W-1:0] out_data_reg;
    logic               out_valid_reg;

    logic [MAG_W-1:0]   mag;
    logic               neg;
    logic [SQ_W-1:0]    sq_next;
    logic [TALLY_W-1:0] tally_next;
    logic               rem_busy;
    logic               rem_done;
    logic               rem_zero;

    assign mag = value_reg[MAG_W-1:0];
    assign neg = value_reg[VALUE_W-1];

    // (d+2)^2 = d^2 + 4d + 4
    assign sq_next    = sq_reg + SQ_W'({div_reg, 2'b00}) + SQ_STEP_C;
    assign tally_next = tally_reg
                      + TALLY_W'(verdict_reg && (tally_reg != TALLY_MAX));

    pcd_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .dividend (mag),
        .divisor  (div_reg),
        .busy     (rem_busy),
        .done     (rem_done),
        .rem_zero (rem_zero)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_tdata;
            last_reg  <= s_tlast;
        end
        if (cmd.set_verdict) begin
            verdict_reg <= cmd.verdict;
        end
        if (cmd.commit && last_reg) begin
            out_data_reg <= tally_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg       <= '0;
            sq_reg        <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                div_reg <= '0;
                sq_reg  <= '0;
            end else if (cmd.init_trial) begin
                div_reg <= FIRST_DIV;
                sq_reg  <= FIRST_SQ;
            end else if (cmd.advance) begin
                div_reg <= div_reg + DIV_W'(2);
                sq_reg  <= sq_next;
            end

            if (cmd.commit) begin
                tally_reg <= last_reg ? '0 : tally_next;
            end

            if (cmd.commit && last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.is_two      = !neg && (mag == MAG_TWO);
        sts.settled_no  = neg || (mag < MAG_TWO) || (!mag[0] && (mag != MAG_TWO));
        sts.sq_over     = sq_reg > {1'b0, mag};
        sts.div_done    = rem_done;
        sts.rem_zero    = rem_zero;
        sts.last        = last_reg;
        sts.out_blocked = out_valid_reg && !m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_sq_tracks_div: assert property (@(posedge aclk) disable iff (!aresetn)
        !rem_busy |-> (sq_reg == SQ_W'(div_reg) * SQ_W'(div_reg)))
        else $error("square register out of step with divisor");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && last_reg) |-> !(out_valid_reg && !m_tready))
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/pcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcd_ctrl
// Sequencer: classify the element, step trial divisors, commit the verdict.
// ----------------------------------------------------------------------------
module pcd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  pcd_pkg::sts_t  sts,
    output pcd_pkg::cmd_t  cmd
);
    import pcd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (sts.is_two) begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b1;
                    state_next      = ST_FINISH;
                end else if (sts.settled_no) begin
                    cmd.set_verdict = 1'b1;
                    state_next      = ST_FINISH;
                end else begin
                    cmd.init_trial = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.sq_over) begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b1;
                    state_next      = ST_FINISH;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (sts.div_done) begin
                    if (sts.rem_zero) begin
                        cmd.set_verdict = 1'b1;
                        state_next      = ST_FINISH;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_CHECK;
                    end
                end
            end
            ST_FINISH: begin
                if (!sts.last || !sts.out_blocked) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/prime_count_trial_division_unit.sv =====
// ----------------------------------------------------------------------------
// prime_count_trial_division_unit
// Counts the primes in a stream of signed 32-bit integers by trial division.
// ----------------------------------------------------------------------------
// Input channel (s_): one transfer per element, value on s_tdata, s_tlast
// high on the final element of a sequence. Result channel (m_): one transfer
// per sequence, after its final element, carrying the number of primes seen
// (saturating at all ones) on m_tdata.
// Elements are handled one at a time; s_tready is high only between items.
// Negative values, 0, 1, 2 and even values settle in the classify step with
// no divisor tried. Odd values run odd divisors 3, 5, 7 ... while d*d <= value;
// each divisor takes one bound check, 31 remainder steps and a done report.
// A divisor that leaves no remainder ends the item as composite; once d*d
// exceeds the value, the item ends as prime.
// The result sits in an output register: the next sequence is accepted and
// processed while it waits; only the following final element holds in its
// finish step until m_tready frees the register.
// Reset clears the tally, the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module prime_count_trial_division_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pcd_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pcd_pkg::TALLY_W-1:0]   m_tdata    // [31:0] prime_total
);
    import pcd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: owns the input handshake and all step decisions
    pcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: operand, divisor and square, remainder unit, tally, output
    pcd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== tb/prime_count_trial_division_unit_tb.sv =====
// ----------------------------------------------------------------------------
// prime_count_trial_division_unit_tb
// Self-checking bench for the trial-division prime counter. Short directed
// sequences come first: negatives, 0, 1, 2, even values, odd squares and the
// largest positive value. Random sequences follow, in three traffic phases:
// receiver stalls, then sender gaps, then full rate with one long output
// hold-off. A scoreboard predicts the prime count of every sequence and
// compares it with each result transfer.
// ----------------------------------------------------------------------------
module prime_count_trial_division_unit_tb;

    localparam int          MAX_SHOWN    = 10;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          HOLD_CYCLES  = 3000;
    localparam int unsigned CYCLE_LIMIT  = 10_000_000;

    typedef logic [pcd_pkg::VALUE_W-1:0] element_t;
    typedef logic [pcd_pkg::TALLY_W-1:0] total_t;

    // Predicts the prime count of each sequence and checks result transfers.
    class prime_tally_scoreboard;
        total_t      running_tally;
        total_t      pending_totals[$];
        int unsigned totals_noted;
        int unsigned mismatches;

        function new();
            running_tally = '0;
            totals_noted  = 0;
            mismatches    = 0;
        endfunction

        // Trial division with an exact square bound; 2 counts as prime.
        function bit is_prime_value(element_t raw);
            longint unsigned magnitude;
            longint unsigned divisor;
            if (raw[pcd_pkg::VALUE_W-1])
                return 1'b0;
            magnitude = raw;
            if (magnitude < 2)
                return 1'b0;
            if (magnitude == 2)
                return 1'b1;
            if (magnitude[0] == 1'b0)
                return 1'b0;
            for (divisor = 3; divisor * divisor <= magnitude; divisor += 2) begin
                if (magnitude % divisor == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_element(element_t value, bit last);
            if (is_prime_value(value) && running_tally != pcd_pkg::TALLY_MAX)
                running_tally++;
            if (last) begin
                pending_totals.push_back(running_tally);
                running_tally = '0;
                totals_noted++;
            end
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%s", what);
        endfunction

        function void check_total(total_t seen);
            total_t wanted;
            if (pending_totals.size() == 0) begin
                report($sformatf("unexpected prime_total %0d with no sequence pending",
                                 seen));
                return;
            end
            wanted = pending_totals.pop_front();
            if (seen !== wanted)
                report($sformatf("prime_total mismatch: expected %0d, got %0d",
                                 wanted, seen));
        endfunction
    endclass

    logic     aclk     = 1'b0;
    logic     aresetn  = 1'b0;
    logic     s_tvalid = 1'b0;
    logic     s_tready;
    element_t s_tdata  = '0;     // [31:0] value
    logic     s_tlast  = 1'b0;
    logic     m_tvalid;
    logic     m_tready = 1'b0;
    total_t   m_tdata;           // [31:0] prime_total

    prime_tally_scoreboard prime_board;
    int unsigned           cycle_count   = 0;
    int unsigned           elements_sent = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_request  = 0;

    prime_count_trial_division_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Guard against a hung block; the slowest legal run (one prime near 2^31
    // plus every random element a long trial) stays well inside this limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: stall at random, or hold off for a fixed stretch on request
    // so that the output register stays full and the input backs up.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(negedge aclk);
                hold_request = 0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Check every result transfer against the oldest predicted total.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            prime_board.check_total(m_tdata);
    end

    // Offer one element, entered and left at a falling edge; s_tvalid stays
    // high into the next call unless a gap is drawn.
    task automatic send_element(input element_t value, input bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        prime_board.note_element(value, last);
        elements_sent++;
        @(negedge aclk);
    endtask

    // Mostly cheap values: large odd values are kept to multiples of three so
    // that they settle after one divisor, and true trial runs stay below 2^18.
    function automatic element_t random_element();
        int unsigned pick;
        int unsigned half;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return $urandom_range(0, 2047) * 2 + 1;
        if (pick < 50)
            return $urandom_range(0, 16);
        if (pick < 62)
            return $urandom | 32'h8000_0000;
        if (pick < 72)
            return $urandom & 32'h7FFF_FFFE;
        if (pick < 87) begin
            half = $urandom_range(0, 357_913_940);
            return 3 * (2 * half + 1);
        end
        return $urandom_range(0, 131_071) * 2 + 1;
    endfunction

    task automatic send_random_sequence();
        int length;
        length = $urandom_range(1, 5);
        for (int i = 1; i <= length; i++)
            send_element(random_element(), i == length);
    endtask

    initial begin
        element_t directed_values[$];
        bit       directed_lasts[$];

        prime_board = new();

        // Hold reset, then release it on a falling edge.
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Negatives, zero, one and two in one sequence: one prime.
        directed_values = '{32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2};
        directed_lasts  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
        // Three alone: prime with no divisor tried.
        directed_values.push_back(32'd3);
        directed_lasts.push_back(1'b1);
        // Odd squares sit exactly on the bound; small primes around them.
        directed_values = {directed_values, 32'd4, 32'd9, 32'd15, 32'd25, 32'd49,
                           32'd5, 32'd7, 32'd11, 32'd65537};
        directed_lasts  = {directed_lasts, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                           1'b0, 1'b0, 1'b0, 1'b1};
        // Top of the range: large even, large odd composite, then 2^31-1,
        // which is prime and runs the longest trial.
        directed_values = {directed_values, 32'h7FFF_FFFE, 32'h7FFF_FFFD,
                           32'h7FFF_FFFF};
        directed_lasts  = {directed_lasts, 1'b0, 1'b0, 1'b1};
        // Single-element sequences: two alone, and one sequence with no prime.
        directed_values = {directed_values, 32'd2, 32'd1};
        directed_lasts  = {directed_lasts, 1'b1, 1'b1};

        send_idle_pct = 15;
        recv_idle_pct = 61;
        foreach (directed_values[i])
            send_element(directed_values[i], directed_lasts[i]);

        // Phase one: sender gaps light, receiver stalls heavy.
        while (elements_sent < 45)
            send_random_sequence();

        // Phase two: the other way round.
        send_idle_pct = 61;
        recv_idle_pct = 15;
        while (elements_sent < 70)
            send_random_sequence();

        // Phase three: full rate, with one long output hold-off while the
        // sender keeps offering. Three quick one-element sequences fill the
        // output register and then back up the input behind it.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        repeat (3) send_element(32'd2, 1'b1);
        while (elements_sent < 100)
            send_random_sequence();
        s_tvalid <= 1'b0;

        // Drain the outstanding totals, then allow a quiet tail.
        while (prime_board.pending_totals.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (prime_board.mismatches == 0 && prime_board.pending_totals.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
